FILE: rtl/sip_pkg.sv
// Shared types for the segment intersection point unit.
// No dependencies; imported by the geometry front end, the divider and the top level.
package sip_pkg;

    // Control word that travels down the pipeline beside each pair
    typedef struct packed {
        logic vld;    // stage holds a word
        logic ep;     // an endpoint test matched
        logic crs;    // proper crossing with a non-zero determinant
        logic neg_x;  // x quotient is negative
        logic neg_y;  // y quotient is negative
    } sip_meta_t;

endpackage

FILE: rtl/sip_geom.sv
// Geometry front end: differences, orientation and Cramer products, endpoint choice.
// Depends on sip_pkg; feeds sip_div with numerator and determinant magnitudes.
module sip_geom #(
    parameter int W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic signed [W-1:0]    s1_start_x,
    input  logic signed [W-1:0]    s1_start_y,
    input  logic signed [W-1:0]    s1_end_x,
    input  logic signed [W-1:0]    s1_end_y,
    input  logic signed [W-1:0]    s2_start_x,
    input  logic signed [W-1:0]    s2_start_y,
    input  logic signed [W-1:0]    s2_end_x,
    input  logic signed [W-1:0]    s2_end_y,
    output sip_pkg::sip_meta_t     meta,
    output logic [3*W+4:0]         num_x,
    output logic [3*W+4:0]         num_y,
    output logic [2*W+2:0]         det,
    output logic signed [W-1:0]    ep_x,
    output logic signed [W-1:0]    ep_y
);
    import sip_pkg::*;

    localparam int DW  = W + 1;        // coordinate difference
    localparam int PW  = 2 * W + 2;    // first products
    localparam int OW  = 2 * W + 3;    // orientation, det, c terms
    localparam int NPW = 3 * W + 4;    // numerator products
    localparam int NW  = 3 * W + 5;    // numerators

    // ---------------- stage 0: input register
    logic                 v0_reg;
    logic signed [W-1:0]  p1x_reg, p1y_reg, q1x_reg, q1y_reg;
    logic signed [W-1:0]  p2x_reg, p2y_reg, q2x_reg, q2y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1x_reg <= s1_start_x;
            p1y_reg <= s1_start_y;
            q1x_reg <= s1_end_x;
            q1y_reg <= s1_end_y;
            p2x_reg <= s2_start_x;
            p2y_reg <= s2_start_y;
            q2x_reg <= s2_end_x;
            q2y_reg <= s2_end_y;
        end
    end

    // ---------------- stage 1: differences and bounding-box tests
    logic                 v1_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [DW-1:0] gx_reg, gy_reg, zx_reg, zy_reg;
    logic signed [W-1:0]  p1x1_reg, p1y1_reg, q1x1_reg, q1y1_reg;
    logic signed [W-1:0]  p2x1_reg, p2y1_reg, q2x1_reg, q2y1_reg;
    logic [3:0]           box1_reg;

    logic signed [W-1:0]  lx1, hx1, ly1, hy1, lx2, hx2, ly2, hy2;
    logic [3:0]           box1_next;

    always_comb
    begin
        lx1 = (p1x_reg < q1x_reg) ? p1x_reg : q1x_reg;
        hx1 = (p1x_reg < q1x_reg) ? q1x_reg : p1x_reg;
        ly1 = (p1y_reg < q1y_reg) ? p1y_reg : q1y_reg;
        hy1 = (p1y_reg < q1y_reg) ? q1y_reg : p1y_reg;
        lx2 = (p2x_reg < q2x_reg) ? p2x_reg : q2x_reg;
        hx2 = (p2x_reg < q2x_reg) ? q2x_reg : p2x_reg;
        ly2 = (p2y_reg < q2y_reg) ? p2y_reg : q2y_reg;
        hy2 = (p2y_reg < q2y_reg) ? q2y_reg : p2y_reg;
        box1_next[0] = (p2x_reg >= lx1) && (p2x_reg <= hx1) &&
                       (p2y_reg >= ly1) && (p2y_reg <= hy1);
        box1_next[1] = (q2x_reg >= lx1) && (q2x_reg <= hx1) &&
                       (q2y_reg >= ly1) && (q2y_reg <= hy1);
        box1_next[2] = (p1x_reg >= lx2) && (p1x_reg <= hx2) &&
                       (p1y_reg >= ly2) && (p1y_reg <= hy2);
        box1_next[3] = (q1x_reg >= lx2) && (q1x_reg <= hx2) &&
                       (q1y_reg >= ly2) && (q1y_reg <= hy2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1x_reg  <= DW'(q1x_reg) - DW'(p1x_reg);
            d1y_reg  <= DW'(q1y_reg) - DW'(p1y_reg);
            d2x_reg  <= DW'(q2x_reg) - DW'(p2x_reg);
            d2y_reg  <= DW'(q2y_reg) - DW'(p2y_reg);
            ux_reg   <= DW'(p2x_reg) - DW'(p1x_reg);
            uy_reg   <= DW'(p2y_reg) - DW'(p1y_reg);
            vx_reg   <= DW'(q2x_reg) - DW'(p1x_reg);
            vy_reg   <= DW'(q2y_reg) - DW'(p1y_reg);
            gx_reg   <= DW'(p1x_reg) - DW'(p2x_reg);
            gy_reg   <= DW'(p1y_reg) - DW'(p2y_reg);
            zx_reg   <= DW'(q1x_reg) - DW'(p2x_reg);
            zy_reg   <= DW'(q1y_reg) - DW'(p2y_reg);
            p1x1_reg <= p1x_reg;
            p1y1_reg <= p1y_reg;
            q1x1_reg <= q1x_reg;
            q1y1_reg <= q1y_reg;
            p2x1_reg <= p2x_reg;
            p2y1_reg <= p2y_reg;
            q2x1_reg <= q2x_reg;
            q2y1_reg <= q2y_reg;
            box1_reg <= box1_next;
        end
    end

    // ---------------- stage 2: cross products
    logic                 v2_reg;
    logic signed [PW-1:0] o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    logic signed [PW-1:0] o3a_reg, o3b_reg, o4a_reg, o4b_reg;
    logic signed [PW-1:0] dta_reg, dtb_reg, c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    logic signed [DW-1:0] d1x2_reg, d1y2_reg, d2x2_reg, d2y2_reg;
    logic signed [W-1:0]  p1x2_reg, p1y2_reg, q1x2_reg, q1y2_reg;
    logic signed [W-1:0]  p2x2_reg, p2y2_reg, q2x2_reg, q2y2_reg;
    logic [3:0]           box2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o1a_reg  <= PW'(d1x_reg) * PW'(uy_reg);
            o1b_reg  <= PW'(d1y_reg) * PW'(ux_reg);
            o2a_reg  <= PW'(d1x_reg) * PW'(vy_reg);
            o2b_reg  <= PW'(d1y_reg) * PW'(vx_reg);
            o3a_reg  <= PW'(d2x_reg) * PW'(gy_reg);
            o3b_reg  <= PW'(d2y_reg) * PW'(gx_reg);
            o4a_reg  <= PW'(d2x_reg) * PW'(zy_reg);
            o4b_reg  <= PW'(d2y_reg) * PW'(zx_reg);
            dta_reg  <= PW'(d1x_reg) * PW'(d2y_reg);
            dtb_reg  <= PW'(d1y_reg) * PW'(d2x_reg);
            c1a_reg  <= PW'(d1x_reg) * PW'(p1y1_reg);
            c1b_reg  <= PW'(d1y_reg) * PW'(p1x1_reg);
            c2a_reg  <= PW'(d2x_reg) * PW'(p2y1_reg);
            c2b_reg  <= PW'(d2y_reg) * PW'(p2x1_reg);
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            d2x2_reg <= d2x_reg;
            d2y2_reg <= d2y_reg;
            p1x2_reg <= p1x1_reg;
            p1y2_reg <= p1y1_reg;
            q1x2_reg <= q1x1_reg;
            q1y2_reg <= q1y1_reg;
            p2x2_reg <= p2x1_reg;
            p2y2_reg <= p2y1_reg;
            q2x2_reg <= q2x1_reg;
            q2y2_reg <= q2y1_reg;
            box2_reg <= box1_reg;
        end
    end

    // ---------------- stage 3: orientation signs, endpoint priority, det and c terms
    sip_meta_t            m3_reg, m3_next;
    logic signed [OW-1:0] det3_reg, c13_reg, c23_reg;
    logic signed [DW-1:0] d1x3_reg, d1y3_reg, d2x3_reg, d2y3_reg;
    logic signed [W-1:0]  epx3_reg, epy3_reg, epx3_next, epy3_next;

    logic signed [OW-1:0] or1, or2, or3, or4, det3_next;
    logic                 z1, z2, z3, z4;

    always_comb
    begin
        or1       = OW'(o1a_reg) - OW'(o1b_reg);
        or2       = OW'(o2a_reg) - OW'(o2b_reg);
        or3       = OW'(o3a_reg) - OW'(o3b_reg);
        or4       = OW'(o4a_reg) - OW'(o4b_reg);
        det3_next = OW'(dta_reg) - OW'(dtb_reg);
        z1        = (or1 == '0);
        z2        = (or2 == '0);
        z3        = (or3 == '0);
        z4        = (or4 == '0);

        m3_next       = '0;
        m3_next.vld   = v2_reg;
        m3_next.ep    = 1'b1;
        epx3_next     = '0;
        epy3_next     = '0;
        // endpoint tests in fixed priority order
        if (z1 && box2_reg[0])
        begin
            epx3_next = p2x2_reg;
            epy3_next = p2y2_reg;
        end
        else if (z2 && box2_reg[1])
        begin
            epx3_next = q2x2_reg;
            epy3_next = q2y2_reg;
        end
        else if (z3 && box2_reg[2])
        begin
            epx3_next = p1x2_reg;
            epy3_next = p1y2_reg;
        end
        else if (z4 && box2_reg[3])
        begin
            epx3_next = q1x2_reg;
            epy3_next = q1y2_reg;
        end
        else
        begin
            m3_next.ep = 1'b0;
        end
        // proper crossing: signs differ on both segments
        m3_next.crs = ((z1 != z2) || (or1[OW-1] != or2[OW-1])) &&
                      ((z3 != z4) || (or3[OW-1] != or4[OW-1])) &&
                      (det3_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_reg <= '0;
        end
        else if (en)
        begin
            m3_reg <= m3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det3_reg <= det3_next;
            c13_reg  <= OW'(c1a_reg) - OW'(c1b_reg);
            c23_reg  <= OW'(c2a_reg) - OW'(c2b_reg);
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
            d2x3_reg <= d2x2_reg;
            d2y3_reg <= d2y2_reg;
            epx3_reg <= epx3_next;
            epy3_reg <= epy3_next;
        end
    end

    // ---------------- stage 4: numerator products
    sip_meta_t             m4_reg;
    logic signed [NPW-1:0] nxa_reg, nxb_reg, nya_reg, nyb_reg;
    logic signed [OW-1:0]  det4_reg;
    logic signed [W-1:0]   epx4_reg, epy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m4_reg <= '0;
        end
        else if (en)
        begin
            m4_reg <= m3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxa_reg  <= NPW'(d2x3_reg) * NPW'(c13_reg);
            nxb_reg  <= NPW'(d1x3_reg) * NPW'(c23_reg);
            nya_reg  <= NPW'(d2y3_reg) * NPW'(c13_reg);
            nyb_reg  <= NPW'(d1y3_reg) * NPW'(c23_reg);
            det4_reg <= det3_reg;
            epx4_reg <= epx3_reg;
            epy4_reg <= epy3_reg;
        end
    end

    // ---------------- stage 5: numerators, magnitudes and quotient signs
    sip_meta_t            m5_reg, m5_next;
    logic [NW-1:0]        nx5_reg, ny5_reg;
    logic [OW-1:0]        det5_reg;
    logic signed [W-1:0]  epx5_reg, epy5_reg;
    logic signed [NW-1:0] sx, sy;

    always_comb
    begin
        sx            = NW'(nxa_reg) - NW'(nxb_reg);
        sy            = NW'(nya_reg) - NW'(nyb_reg);
        m5_next       = m4_reg;
        m5_next.neg_x = sx[NW-1] ^ det4_reg[OW-1];
        m5_next.neg_y = sy[NW-1] ^ det4_reg[OW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m5_reg <= '0;
        end
        else if (en)
        begin
            m5_reg <= m5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg  <= sx[NW-1] ? NW'(-sx) : NW'(sx);
            ny5_reg  <= sy[NW-1] ? NW'(-sy) : NW'(sy);
            det5_reg <= det4_reg[OW-1] ? OW'(-det4_reg) : OW'(det4_reg);
            epx5_reg <= epx4_reg;
            epy5_reg <= epy4_reg;
        end
    end

    assign meta  = m5_reg;
    assign num_x = nx5_reg;
    assign num_y = ny5_reg;
    assign det   = det5_reg;
    assign ep_x  = epx5_reg;
    assign ep_y  = epy5_reg;

endmodule

FILE: rtl/sip_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on sip_pkg; fed by sip_geom, read by the top level.
module sip_div #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  sip_pkg::sip_meta_t    meta_in,
    input  logic [3*W+4:0]        num_x,
    input  logic [3*W+4:0]        num_y,
    input  logic [2*W+2:0]        det,
    input  logic signed [W-1:0]   ep_x_in,
    input  logic signed [W-1:0]   ep_y_in,
    output sip_pkg::sip_meta_t    meta_out,
    output logic [W-1:0]          quo_x,
    output logic [W-1:0]          quo_y,
    output logic signed [W-1:0]   ep_x_out,
    output logic signed [W-1:0]   ep_y_out
);
    import sip_pkg::*;

    localparam int NW = 3 * W + 5;
    localparam int OW = 2 * W + 3;

    // entry 0 holds the incoming word, entry k+1 the word after step k
    sip_meta_t           m_reg   [W+1];
    logic [NW-1:0]       rx_reg  [W+1];
    logic [NW-1:0]       ry_reg  [W+1];
    logic [W-1:0]        qx_reg  [W+1];
    logic [W-1:0]        qy_reg  [W+1];
    logic [OW-1:0]       d_reg   [W+1];
    logic signed [W-1:0] epx_reg [W+1];
    logic signed [W-1:0] epy_reg [W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg[0] <= '0;
        end
        else if (en)
        begin
            m_reg[0] <= meta_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]  <= num_x;
            ry_reg[0]  <= num_y;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            d_reg[0]   <= det;
            epx_reg[0] <= ep_x_in;
            epy_reg[0] <= ep_y_in;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        localparam int SH = W - 1 - k;
        logic [NW-1:0] dsh;
        logic          tx, ty;

        // trial subtract of the divisor at this bit weight
        assign dsh = NW'(d_reg[k]) << SH;
        assign tx  = (rx_reg[k] >= dsh);
        assign ty  = (ry_reg[k] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_reg[k+1] <= '0;
            end
            else if (en)
            begin
                m_reg[k+1] <= m_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]  <= tx ? (rx_reg[k] - dsh) : rx_reg[k];
                ry_reg[k+1]  <= ty ? (ry_reg[k] - dsh) : ry_reg[k];
                qx_reg[k+1]  <= qx_reg[k] | (W'(tx) << SH);
                qy_reg[k+1]  <= qy_reg[k] | (W'(ty) << SH);
                d_reg[k+1]   <= d_reg[k];
                epx_reg[k+1] <= epx_reg[k];
                epy_reg[k+1] <= epy_reg[k];
            end
        end
    end

    assign meta_out = m_reg[W];
    assign quo_x    = qx_reg[W];
    assign quo_y    = qy_reg[W];
    assign ep_x_out = epx_reg[W];
    assign ep_y_out = epy_reg[W];

endmodule

FILE: rtl/segment_intersection_point_unit.sv
// Segment intersection point unit: one pair of 2D segments in, one point out per word.
// A new pair is taken every cycle while the result side is not stalled; most of the depth
// comes from the restoring divider, which resolves one quotient bit per stage in both lanes.
// A stall on the result side freezes the whole pipeline, so pair_stall follows
// point_stall whenever a finished word is waiting. Depends on sip_pkg, sip_geom, sip_div.
module segment_intersection_point_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pair_valid,
    output logic                         pair_stall,
    input  logic signed [COORD_BITS-1:0] s1_start_x,
    input  logic signed [COORD_BITS-1:0] s1_start_y,
    input  logic signed [COORD_BITS-1:0] s1_end_x,
    input  logic signed [COORD_BITS-1:0] s1_end_y,
    input  logic signed [COORD_BITS-1:0] s2_start_x,
    input  logic signed [COORD_BITS-1:0] s2_start_y,
    input  logic signed [COORD_BITS-1:0] s2_end_x,
    input  logic signed [COORD_BITS-1:0] s2_end_y,
    output logic                         point_valid,
    input  logic                         point_stall,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y
);
    import sip_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int NW = 3 * W + 5;
    localparam int OW = 2 * W + 3;

    logic                en;
    sip_meta_t           g_meta, d_meta;
    logic [NW-1:0]       g_num_x, g_num_y;
    logic [OW-1:0]       g_det;
    logic signed [W-1:0] g_ep_x, g_ep_y, d_ep_x, d_ep_y;
    logic [W-1:0]        quo_x, quo_y;

    // whole pipeline advances unless a held result is being stalled
    assign en         = !(point_valid && point_stall);
    assign pair_stall = !en;

    sip_geom #(.W(W)) u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (pair_valid),
        .s1_start_x (s1_start_x),
        .s1_start_y (s1_start_y),
        .s1_end_x   (s1_end_x),
        .s1_end_y   (s1_end_y),
        .s2_start_x (s2_start_x),
        .s2_start_y (s2_start_y),
        .s2_end_x   (s2_end_x),
        .s2_end_y   (s2_end_y),
        .meta       (g_meta),
        .num_x      (g_num_x),
        .num_y      (g_num_y),
        .det        (g_det),
        .ep_x       (g_ep_x),
        .ep_y       (g_ep_y)
    );

    sip_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .meta_in  (g_meta),
        .num_x    (g_num_x),
        .num_y    (g_num_y),
        .det      (g_det),
        .ep_x_in  (g_ep_x),
        .ep_y_in  (g_ep_y),
        .meta_out (d_meta),
        .quo_x    (quo_x),
        .quo_y    (quo_y),
        .ep_x_out (d_ep_x),
        .ep_y_out (d_ep_y)
    );

    // output register: apply quotient sign and pick the reported point
    logic                valid_reg, hit_reg, hit_next;
    logic signed [W-1:0] x_reg, y_reg, x_next, y_next;

    always_comb
    begin
        hit_next = d_meta.ep || d_meta.crs;
        x_next   = '0;
        y_next   = '0;
        if (d_meta.ep)
        begin
            x_next = d_ep_x;
            y_next = d_ep_y;
        end
        else if (d_meta.crs)
        begin
            x_next = d_meta.neg_x ? W'(-quo_x) : W'(quo_x);
            y_next = d_meta.neg_y ? W'(-quo_y) : W'(quo_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_meta.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign point_valid = valid_reg;
    assign hit         = hit_reg;
    assign cross_x     = x_reg;
    assign cross_y     = y_reg;

endmodule

FILE: rtl/sip_checker.sv
// Port-level checks for the segment intersection point unit, with the bind that attaches them.
// Depends only on the top level's ports.
module sip_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pair_valid,
    input logic                  pair_stall,
    input logic                  point_valid,
    input logic                  point_stall,
    input logic                  hit,
    input logic [COORD_BITS-1:0] cross_x,
    input logic [COORD_BITS-1:0] cross_y
);

    // a miss always reports the origin
    a_miss_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
        else $error("miss word with non-zero point");

    // the input side only backs up when a finished word is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (point_valid && point_stall))
        else $error("pair_stall without a stalled result");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_stall) |=>
        (point_valid && $stable(hit) && $stable(cross_x) && $stable(cross_y)))
        else $error("stalled result changed");

    // a stalled pair word stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && pair_stall) |=> pair_valid)
        else $error("pair word withdrawn while stalled");

    // no result is valid straight after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !point_valid)
        else $error("result valid straight after reset");

endmodule

bind segment_intersection_point_unit sip_checker #(.COORD_BITS(COORD_BITS)) u_sip_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .hit         (hit),
    .cross_x     (cross_x),
    .cross_y     (cross_y)
);
